// ===== design/pedometer_step_detector_macros.svh =====
// assertion macros shared by the step detector checker
// no dependencies
`ifndef PEDOMETER_STEP_DETECTOR_MACROS_SVH
`define PEDOMETER_STEP_DETECTOR_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PSD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("step detector assertion failed");

// antecedent in one cycle implies consequent in the next
`define PSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("step detector sequence assertion failed");

`endif

// ===== design/psd_pkg.sv =====
// shared types and constants of the pedometer step detector
// no dependencies
`default_nettype none

package psd_pkg;

  localparam int WINDOW_DEPTH_DEF = 8;

  localparam int MAG_W  = 19;
  localparam int THR_W  = 12;
  localparam int INT_W  = 16;
  localparam int TICK_W = 32;
  localparam int CNT_W  = 32;
  localparam int ACC_W  = 16;
  localparam int IDX_W  = 2;
  localparam int CFG_W  = 16;

  // square root over (sum of squares << 16)
  localparam int SQ_W    = 32;
  localparam int RAD_W   = 48;
  localparam int ROOT_IT = 24;

  // floor(r / 30) = ((r >> 1) * RECIP_15) >> RECIP_SH for r below 2^24
  localparam logic [23:0] RECIP_15 = 24'd8947849;
  localparam int          RECIP_SH = 27;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MIN_INTERVAL = 2'd0;
  localparam logic [IDX_W-1:0] REG_INIT_THR     = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_SWING    = 2'd2;

  localparam logic [INT_W-1:0] MIN_INTERVAL_RST = 16'd350;
  localparam logic [THR_W-1:0] INIT_THR_RST     = 12'd512;
  localparam logic [THR_W-1:0] MIN_SWING_RST    = 12'd333;

  // peak qualification and mean levels, Q8
  localparam logic [MAG_W-1:0] BIG_PEAK = 19'd5120;
  localparam int LEVEL_8 = 2048;
  localparam int LEVEL_7 = 1792;
  localparam int LEVEL_4 = 1024;
  localparam int LEVEL_3 = 768;

  localparam logic [THR_W-1:0] THR_4P3 = 12'd1101;
  localparam logic [THR_W-1:0] THR_3P3 = 12'd845;
  localparam logic [THR_W-1:0] THR_2P3 = 12'd589;
  localparam logic [THR_W-1:0] THR_2P0 = 12'd512;
  localparam logic [THR_W-1:0] THR_1P3 = 12'd333;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_DIV,
    ST_UPD
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       sq_step;
    logic [1:0] sq_sel;
    logic       sq_last;
    logic       root_step;
    logic       div;
    logic       upd;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/pedometer_step_detector.sv =====
// Pedometer step detector, top level.
// Input channel: one word per sample (accel_x/y/z, now_tick) on in_valid_i/in_ready_o.
// Output channel: one result word per sample (step_found, step_total,
//   threshold_now, magnitude) on out_valid_o/out_ready_i.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   0 min_step_interval, 1 initial_threshold (also loads the threshold),
//   2 min_swing; other indexes are ignored. cfg_ready_o is always high.
// The sample is captured at the accepting edge, then passes through the shared
//   squarer, the one-bit-per-cycle square root, the reciprocal divide by 30 and
//   the update step; the block works on one sample at a time.
// The output register decouples the sides: a new sample is taken while the
//   previous result waits; if the receiver stalls, the next result is held
//   in the update step until the register frees.
// Reset (asynchronous, active low) clears the state, loads the register
//   reset values and empties the swing window; no clearing pass is needed.
// depends on psd_pkg, psd_ctrl, psd_datapath
`default_nettype none

module pedometer_step_detector #(
  parameter int WINDOW_DEPTH = psd_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic signed [15:0]          accel_x_i,
  input  wire logic signed [15:0]          accel_y_i,
  input  wire logic signed [15:0]          accel_z_i,
  input  wire logic [psd_pkg::TICK_W-1:0]  now_tick_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             step_found_o,
  output logic [psd_pkg::CNT_W-1:0]        step_total_o,
  output logic [psd_pkg::THR_W-1:0]        threshold_now_o,
  output logic [psd_pkg::MAG_W-1:0]        magnitude_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [psd_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire logic [psd_pkg::CFG_W-1:0]   cfg_data_i
);

  psd_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // sequencer
  psd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // datapath
  psd_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .accel_x_i       (accel_x_i),
    .accel_y_i       (accel_y_i),
    .accel_z_i       (accel_z_i),
    .now_tick_i      (now_tick_i),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .step_found_o    (step_found_o),
    .step_total_o    (step_total_o),
    .threshold_now_o (threshold_now_o),
    .magnitude_o     (magnitude_o)
  );

endmodule

`default_nettype wire

// ===== design/psd_ctrl.sv =====
// sequencer of the step detector: squares, root steps, divide, update
// depends on psd_pkg
`default_nettype none

module psd_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output psd_pkg::cmd_t    cmd_o
);

  psd_pkg::state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psd_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      psd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = psd_pkg::ST_SQ;
        end
      end
      psd_pkg::ST_SQ: begin
        cmd_o.sq_step = 1'b1;
        cmd_o.sq_sel  = cnt_q[1:0];
        if (cnt_q == 5'd2) begin
          cmd_o.sq_last = 1'b1;
          cnt_d         = '0;
          state_d       = psd_pkg::ST_ROOT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      psd_pkg::ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == 5'(psd_pkg::ROOT_IT - 1)) begin
          cnt_d   = '0;
          state_d = psd_pkg::ST_DIV;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      psd_pkg::ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = psd_pkg::ST_UPD;
      end
      psd_pkg::ST_UPD: begin
        // wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.upd   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = psd_pkg::ST_IDLE;
        end
      end
      default: state_d = psd_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/psd_datapath.sv =====
// datapath: magnitude, peak/valley tracking, swing window, config registers
// depends on psd_pkg
`default_nettype none

module psd_datapath #(
  parameter int WINDOW_DEPTH = psd_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  psd_pkg::cmd_t                    cmd_i,
  input  wire logic signed [15:0]          accel_x_i,
  input  wire logic signed [15:0]          accel_y_i,
  input  wire logic signed [15:0]          accel_z_i,
  input  wire logic [psd_pkg::TICK_W-1:0]  now_tick_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [psd_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire logic [psd_pkg::CFG_W-1:0]   cfg_data_i,
  output logic                             step_found_o,
  output logic [psd_pkg::CNT_W-1:0]        step_total_o,
  output logic [psd_pkg::THR_W-1:0]        threshold_now_o,
  output logic [psd_pkg::MAG_W-1:0]        magnitude_o
);

  localparam int MAG_W  = psd_pkg::MAG_W;
  localparam int THR_W  = psd_pkg::THR_W;
  localparam int RAD_W  = psd_pkg::RAD_W;
  localparam int WIDX_W = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = MAG_W + $clog2(WINDOW_DEPTH);
  localparam logic [SUM_W-1:0] SUM_L8 = SUM_W'(psd_pkg::LEVEL_8 * WINDOW_DEPTH);
  localparam logic [SUM_W-1:0] SUM_L7 = SUM_W'(psd_pkg::LEVEL_7 * WINDOW_DEPTH);
  localparam logic [SUM_W-1:0] SUM_L4 = SUM_W'(psd_pkg::LEVEL_4 * WINDOW_DEPTH);
  localparam logic [SUM_W-1:0] SUM_L3 = SUM_W'(psd_pkg::LEVEL_3 * WINDOW_DEPTH);
  localparam logic [FILL_W-1:0] FULL  = FILL_W'(WINDOW_DEPTH);

  // captured sample
  logic signed [15:0]         ax_q, ay_q, az_q;
  logic [psd_pkg::TICK_W-1:0] now_q;

  // config registers
  logic [psd_pkg::INT_W-1:0] min_int_q;
  logic [THR_W-1:0]          min_swing_q;

  // magnitude pipeline
  logic [psd_pkg::SQ_W-1:0] acc_q;
  logic [RAD_W-1:0]         rad_q, root_q, bit_q;
  logic [MAG_W-1:0]         mag_q;

  // tracking state
  logic                       primed_q, rising_q;
  logic [MAG_W-1:0]           prev_q, valley_q;
  logic [7:0]                 run_q, former_q;
  logic [psd_pkg::TICK_W-1:0] last_tick_q;
  logic [THR_W-1:0]           thr_q;
  logic [MAG_W-1:0]           win_q [WINDOW_DEPTH];
  logic [FILL_W-1:0]          fill_q;
  logic [SUM_W-1:0]           sum_q;
  logic [psd_pkg::CNT_W-1:0]  count_q;

  // shared squarer
  logic signed [15:0] sq_in;
  logic signed [31:0] sq_prod;
  logic [psd_pkg::SQ_W-1:0] acc_next;

  always_comb begin
    case (cmd_i.sq_sel)
      2'd0:    sq_in = ax_q;
      2'd1:    sq_in = ay_q;
      default: sq_in = az_q;
    endcase
    sq_prod  = sq_in * sq_in;
    acc_next = acc_q + psd_pkg::SQ_W'($unsigned(sq_prod));
  end

  // one root digit per cycle
  logic [RAD_W-1:0] trial;
  logic             take;
  assign trial = root_q + bit_q;
  assign take  = rad_q >= trial;

  // divide by 30 through reciprocal
  logic [46:0] div_prod;
  assign div_prod = root_q[23:1] * psd_pkg::RECIP_15;

  // peak and step decisions
  logic        rising_n, is_peak, time_ok, do_step, do_win, win_full;
  logic [7:0]  run_n, former_n;
  logic signed [MAG_W+1:0] swing;
  logic [psd_pkg::TICK_W-1:0] elapsed;
  logic [THR_W-1:0] quant;

  always_comb begin
    rising_n = rising_q;
    run_n    = run_q;
    former_n = former_q;
    if (mag_q >= prev_q) begin
      rising_n = 1'b1;
      if (run_q != 8'hFF) run_n = run_q + 8'd1;
    end else begin
      former_n = run_q;
      run_n    = '0;
      rising_n = 1'b0;
    end
    is_peak  = !rising_n && rising_q && (former_n >= 8'd2 || prev_q >= psd_pkg::BIG_PEAK);
    elapsed  = now_q - last_tick_q;
    time_ok  = elapsed >= psd_pkg::TICK_W'(min_int_q);
    swing    = $signed({2'b00, prev_q}) - $signed({2'b00, valley_q});
    do_step  = primed_q && is_peak && time_ok && (swing >= $signed({9'd0, thr_q}));
    do_win   = primed_q && is_peak && time_ok && (swing >= $signed({9'd0, min_swing_q}));
    win_full = fill_q == FULL;
    if (sum_q >= SUM_L8)      quant = psd_pkg::THR_4P3;
    else if (sum_q >= SUM_L7) quant = psd_pkg::THR_3P3;
    else if (sum_q >= SUM_L4) quant = psd_pkg::THR_2P3;
    else if (sum_q >= SUM_L3) quant = psd_pkg::THR_2P0;
    else                      quant = psd_pkg::THR_1P3;
  end

  // sample capture, squares, root and divide
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q  <= accel_x_i;
      ay_q  <= accel_y_i;
      az_q  <= accel_z_i;
      now_q <= now_tick_i;
      acc_q <= '0;
    end
    if (cmd_i.sq_step) acc_q <= acc_next;
    if (cmd_i.sq_last) begin
      rad_q  <= {acc_next, 16'h0000};
      root_q <= '0;
      bit_q  <= RAD_W'(1) << (RAD_W - 2);
    end
    if (cmd_i.root_step) begin
      if (take) begin
        rad_q  <= rad_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.div) mag_q <= div_prod[psd_pkg::RECIP_SH +: MAG_W];
  end

  // swing window entries
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && do_win) begin
      if (!win_full) begin
        win_q[fill_q[WIDX_W-1:0]] <= swing[MAG_W-1:0];
      end else begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) win_q[i] <= win_q[i+1];
        win_q[WINDOW_DEPTH-1] <= swing[MAG_W-1:0];
      end
    end
  end

  // tracking state and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_int_q   <= psd_pkg::MIN_INTERVAL_RST;
      min_swing_q <= psd_pkg::MIN_SWING_RST;
      primed_q    <= 1'b0;
      prev_q      <= '0;
      rising_q    <= 1'b0;
      run_q       <= '0;
      former_q    <= '0;
      valley_q    <= '0;
      last_tick_q <= '0;
      thr_q       <= psd_pkg::INIT_THR_RST;
      fill_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          psd_pkg::REG_MIN_INTERVAL: min_int_q <= cfg_data_i;
          psd_pkg::REG_INIT_THR:     thr_q <= cfg_data_i[THR_W-1:0];
          psd_pkg::REG_MIN_SWING:    min_swing_q <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.upd) begin
        prev_q <= mag_q;
        if (!primed_q) begin
          primed_q <= 1'b1;
        end else begin
          rising_q <= rising_n;
          run_q    <= run_n;
          former_q <= former_n;
          if (!rising_q && rising_n) valley_q <= prev_q;
          if (do_step) count_q <= count_q + 32'd1;
          if (do_step || do_win) last_tick_q <= now_q;
          if (do_win) begin
            if (!win_full) begin
              fill_q <= fill_q + FILL_W'(1);
              sum_q  <= sum_q + SUM_W'(swing[MAG_W-1:0]);
            end else begin
              thr_q <= quant;
              sum_q <= sum_q - SUM_W'(win_q[0]) + SUM_W'(swing[MAG_W-1:0]);
            end
          end
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      step_found_o    <= do_step;
      step_total_o    <= do_step ? count_q + 32'd1 : count_q;
      threshold_now_o <= (do_win && win_full) ? quant : thr_q;
      magnitude_o     <= mag_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/psd_checker.sv =====
// port-level checks of the step detector, bound to the top level
// depends on psd_pkg and pedometer_step_detector_macros.svh
`default_nettype none
`include "pedometer_step_detector_macros.svh"

module psd_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [psd_pkg::CNT_W-1:0]  step_total_o,
  input wire logic                       cfg_valid_i,
  input wire logic                       cfg_ready_o
);

  // a stalled result word holds
  `PSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(step_total_o))

  // one sample at a time: busy after acceptance
  `PSD_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // config writes are never stalled
  `PSD_ASSERT(a_cfg_ready, clk_i, rst_ni, !cfg_valid_i || cfg_ready_o)

endmodule

bind pedometer_step_detector psd_checker u_psd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .step_total_o (step_total_o),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o)
);

`default_nettype wire
